FILE: sv/esf_pkg.sv
`default_nettype none

package esf_pkg;

  localparam int MOTORS    = 4;
  localparam int MOTOR_AW  = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PER_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_COEFF  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COEFF     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MASK       = 3'd4;

  localparam logic [31:0] RST_DIST_PER_COUNT  = 32'd65536;
  localparam logic [31:0] RST_SPEED_PER_COUNT = 32'd65536;
  localparam logic [15:0] RST_FEEDBACK_COEFF  = 16'd27984;
  localparam logic [15:0] RST_INPUT_COEFF     = 16'd2386;
  localparam logic [3:0]  RST_WIDE_MASK       = 4'd3;

  typedef struct packed {
    logic [31:0] dist_per_count;
    logic [31:0] speed_per_count;
    logic [15:0] feedback_coeff;
    logic [15:0] input_coeff;
    logic [3:0]  wide_counter_mask;
  } cfg_t;

  typedef struct packed {
    logic        [31:0] last_count;
    logic signed [47:0] dist_sum;
    logic signed [31:0] prior_speed;
    logic signed [31:0] smoothed_speed;
  } state_t;

  typedef struct packed {
    logic                rd_en;
    logic [MOTOR_AW-1:0] rd_addr;
    logic                wr_en;
    logic [MOTOR_AW-1:0] wr_addr;
    state_t              wr_data;
  } ram_req_t;

  typedef struct packed {
    logic        [1:0]  motor;
    logic signed [31:0] delta;
    logic signed [31:0] step_dist;
    logic signed [47:0] total_dist;
    logic signed [31:0] speed;
    logic signed [31:0] speed_filtered;
  } result_t;

  localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] I48_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] I48_MIN = -64'sd140737488355328;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] c;
    if (v > I32_MAX) c = I32_MAX;
    else if (v < I32_MIN) c = I32_MIN;
    else c = v;
    return signed'(c[31:0]);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] c;
    if (v > I48_MAX) c = I48_MAX;
    else if (v < I48_MIN) c = I48_MIN;
    else c = v;
    return signed'(c[47:0]);
  endfunction

endpackage

`default_nettype wire

FILE: sv/esf_cfg_regs.sv
`default_nettype none

module esf_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [esf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [esf_pkg::CFG_DW-1:0]     cfg_wdata,
  output esf_pkg::cfg_t                       cfg
);

  esf_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dist_per_count    <= esf_pkg::RST_DIST_PER_COUNT;
      cfg_r.speed_per_count   <= esf_pkg::RST_SPEED_PER_COUNT;
      cfg_r.feedback_coeff    <= esf_pkg::RST_FEEDBACK_COEFF;
      cfg_r.input_coeff       <= esf_pkg::RST_INPUT_COEFF;
      cfg_r.wide_counter_mask <= esf_pkg::RST_WIDE_MASK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        esf_pkg::CFG_DIST_PER_COUNT:  cfg_r.dist_per_count    <= cfg_wdata;
        esf_pkg::CFG_SPEED_PER_COUNT: cfg_r.speed_per_count   <= cfg_wdata;
        esf_pkg::CFG_FEEDBACK_COEFF:  cfg_r.feedback_coeff    <= cfg_wdata[15:0];
        esf_pkg::CFG_INPUT_COEFF:     cfg_r.input_coeff       <= cfg_wdata[15:0];
        esf_pkg::CFG_WIDE_MASK:       cfg_r.wide_counter_mask <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: sv/esf_state_ram.sv
`default_nettype none

module esf_state_ram (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire esf_pkg::ram_req_t req,
  output esf_pkg::state_t    rd_data
);

  esf_pkg::state_t                mem [esf_pkg::MOTORS];
  logic [esf_pkg::MOTORS-1:0]     valid_r;
  esf_pkg::state_t                rd_data_r;
  logic                           rd_hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

`default_nettype wire

FILE: sv/esf_core.sv
`default_nettype none

module esf_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire esf_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_motor,
  input  wire logic [31:0]   in_count,
  output logic               in_stall,
  output esf_pkg::ram_req_t  ram_req,
  input  wire esf_pkg::state_t ram_rd,
  input  wire logic          out_full,
  output logic               res_load,
  output esf_pkg::result_t   res
);

  localparam int ACC_W = 52;
  localparam int FRAC  = 15;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(16384);

  typedef enum logic [2:0] {
    S_IDLE, S_DLT, S_MD, S_MS, S_MA, S_MB, S_FIN
  } seq_state_t;

  seq_state_t               state_r;
  logic [1:0]               motor_r;
  logic                     motor_ok_r;
  logic [31:0]              count_r;
  logic signed [31:0]       d_r;
  logic signed [31:0]       sd_r;
  logic signed [47:0]       tot_r;
  logic signed [31:0]       spd_r;
  logic signed [63:0]       prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic                     accept;
  logic [31:0]              diff;
  logic signed [32:0]       raw;
  logic signed [32:0]       neg;
  logic signed [31:0]       d_nxt;
  logic signed [33:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic signed [66:0]       mul_p;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-FRAC-1:0] filt_pre;
  logic signed [31:0]       filt;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign res_load = (state_r == S_FIN) && !out_full;

  // count difference, narrow counters wrap at 16 bits
  always_comb begin
    diff = count_r - ram_rd.last_count;
    if (cfg.wide_counter_mask[motor_r]) begin
      raw = signed'({diff[31], diff});
    end else begin
      raw = signed'({{17{diff[15]}}, diff[15:0]});
    end
    neg = -raw;
    if (!neg[32] && neg[31]) begin
      d_nxt = 32'sh7fffffff;
    end else begin
      d_nxt = signed'(neg[31:0]);
    end
  end

  // one shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MD: begin
        mul_a = 34'(d_r);
        mul_b = signed'({1'b0, cfg.dist_per_count});
      end
      S_MS: begin
        mul_a = 34'(d_r);
        mul_b = signed'({1'b0, cfg.speed_per_count});
      end
      S_MA: begin
        mul_a = 34'(signed'(ram_rd.smoothed_speed));
        mul_b = signed'({17'b0, cfg.feedback_coeff});
      end
      S_MB: begin
        mul_a = 34'(spd_r) + 34'(signed'(ram_rd.prior_speed));
        mul_b = signed'({17'b0, cfg.input_coeff});
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    acc_sum  = acc_r + signed'(prod_r[ACC_W-1:0]) + ROUND_BIAS;
    filt_pre = signed'(acc_sum[ACC_W-1:FRAC]);
    filt     = esf_pkg::sat32(64'(filt_pre));
  end

  always_comb begin
    ram_req.rd_en                  = accept;
    ram_req.rd_addr                = esf_pkg::MOTOR_AW'(in_motor);
    ram_req.wr_en                  = res_load && motor_ok_r;
    ram_req.wr_addr                = esf_pkg::MOTOR_AW'(motor_r);
    ram_req.wr_data.last_count     = count_r;
    ram_req.wr_data.dist_sum       = tot_r;
    ram_req.wr_data.prior_speed    = spd_r;
    ram_req.wr_data.smoothed_speed = filt;
  end

  always_comb begin
    res.motor = motor_r;
    if (motor_ok_r) begin
      res.delta          = d_r;
      res.step_dist      = sd_r;
      res.total_dist     = tot_r;
      res.speed          = spd_r;
      res.speed_filtered = filt;
    end else begin
      res.delta          = '0;
      res.step_dist      = '0;
      res.total_dist     = '0;
      res.speed          = '0;
      res.speed_filtered = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            motor_r    <= in_motor;
            motor_ok_r <= (int'(in_motor) < esf_pkg::MOTORS);
            count_r    <= in_count;
            state_r    <= S_DLT;
          end
        end
        S_DLT: begin
          d_r     <= d_nxt;
          state_r <= S_MD;
        end
        S_MD: begin
          prod_r  <= signed'(mul_p[63:0]);
          state_r <= S_MS;
        end
        S_MS: begin
          sd_r    <= esf_pkg::sat32(prod_r);
          prod_r  <= signed'(mul_p[63:0]);
          state_r <= S_MA;
        end
        S_MA: begin
          tot_r   <= esf_pkg::sat48(64'(signed'(ram_rd.dist_sum)) + 64'(sd_r));
          spd_r   <= esf_pkg::sat32(prod_r);
          prod_r  <= signed'(mul_p[63:0]);
          state_r <= S_MB;
        end
        S_MB: begin
          acc_r   <= signed'(prod_r[ACC_W-1:0]);
          prod_r  <= signed'(mul_p[63:0]);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_full) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_wr_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.wr_en |-> res_load)
    else $error("state write without a result");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after result");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DLT))
    else $error("accepted request did not start processing");

endmodule

`default_nettype wire

FILE: sv/encoder_speed_filter.sv
// Per-motor encoder velocity with IIR low-pass. One request (motor, raw
// counter) gives one result. Per-motor state sits in a small synchronous
// memory read at acceptance and written back with the result. A request
// is worked through before the next one can be taken: the memory read,
// the count delta, four passes through the single shared multiplier, and
// a last step to round, saturate and write back. A finished result waits
// in the output register, and the next request is taken meanwhile; it
// holds in its last step only if the previous result is still not taken.
// No clearing pass after reset.
`default_nettype none

module encoder_speed_filter (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [esf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [esf_pkg::CFG_DW-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_motor,
  input  wire logic [31:0]                    in_count,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_motor_out,
  output logic signed [31:0]                  out_delta,
  output logic signed [31:0]                  out_step_dist,
  output logic signed [47:0]                  out_total_dist,
  output logic signed [31:0]                  out_speed,
  output logic signed [31:0]                  out_speed_filtered
);

  esf_pkg::cfg_t      cfg;
  esf_pkg::ram_req_t  ram_req;
  esf_pkg::state_t    ram_rd;
  esf_pkg::result_t   res;
  esf_pkg::result_t   res_r;
  logic               res_load;
  logic               out_valid_r;
  logic               out_full;

  esf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  esf_state_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  esf_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_motor (in_motor),
    .in_count (in_count),
    .in_stall (in_stall),
    .ram_req  (ram_req),
    .ram_rd   (ram_rd),
    .out_full (out_full),
    .res_load (res_load),
    .res      (res)
  );

  assign out_full = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_motor_out      = res_r.motor;
  assign out_delta          = res_r.delta;
  assign out_step_dist      = res_r.step_dist;
  assign out_total_dist     = res_r.total_dist;
  assign out_speed          = res_r.speed;
  assign out_speed_filtered = res_r.speed_filtered;

endmodule

`default_nettype wire
